// File: rtl/core/pfa_pkg.sv
`default_nettype none

package pfa_pkg;

   // Defaults for the top-level parameters
   localparam int MAX_PAGES_DEF = 65536;
   localparam int REF_BITS_DEF  = 8;

   // Fixed field widths
   localparam int PAGE_W    = 16;
   localparam int CNT_W     = 17;
   localparam int PID_W     = 16;
   localparam int VA_W      = 48;
   localparam int REF_OUT_W = 8;
   localparam int OWNER_W   = PID_W + VA_W;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CNT_W-1:0] CNT_SAT  = '1;
   localparam logic [PID_W-1:0] PID_NONE = '1;

   typedef enum logic [2:0] {
      MODE_INIT    = 3'd0,
      MODE_ALLOC   = 3'd1,
      MODE_FREE    = 3'd2,
      MODE_REF_INC = 3'd3,
      MODE_REF_DEC = 3'd4,
      MODE_MAP     = 3'd5,
      MODE_UNMAP   = 3'd6
   } mode_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_EMPTY    = 2'd1,
      STAT_BAD_PAGE = 2'd2,
      STAT_REF_ZERO = 2'd3
   } status_type;

   typedef enum logic {
      REG_PAGE_COUNT = 1'b0,
      REG_FIRST_FREE = 1'b1
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_EXEC  = 3'b010,
      ST_SWEEP = 3'b100
   } state_type;

endpackage

`default_nettype wire

// File: rtl/core/pfa_ram.sv
`default_nettype none

module pfa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 65536
) (
   input  wire  logic                     clock,
   input  wire  logic                     wr_en,
   input  wire  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire  logic [WIDTH-1:0]         wr_data,
   input  wire  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic       [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/core/page_frame_allocator_refcount_top.sv
`default_nettype none

// Page-frame allocator with a LIFO free list and a reference count and owner
// per page, all held in RAMs with a registered read (link, count, owner). For
// an ordinary item the accept edge issues the RAM reads, and the EXEC state,
// once the result register is free, modifies the words and writes them back
// while loading the result register; a new item is only taken after the last
// one has left EXEC. Init sweeps every entry of the RAMs, one per cycle, then
// delivers its word from EXEC. After reset the same sweep clears the tables;
// no item is accepted meanwhile (configuration
// writes are taken). A finished word waits in the result register while the
// next item is accepted.
module page_frame_allocator_refcount_top
   import pfa_pkg::*;
#(
   parameter int MAX_PAGES = MAX_PAGES_DEF,
   parameter int REF_BITS  = REF_BITS_DEF
) (
   input  wire  logic                    clock,
   input  wire  logic                    reset,
   // item channel
   input  wire  logic                    req_valid,
   output logic                          req_stall,
   input  wire  logic [2:0]              req_mode,
   input  wire  logic [PAGE_W-1:0]       req_page_number,
   input  wire  logic signed [PID_W-1:0] req_owner_pid_in,
   input  wire  logic [VA_W-1:0]         req_owner_va_in,
   // result channel
   output logic                          rsp_valid,
   input  wire  logic                    rsp_stall,
   output logic [1:0]                    rsp_status,
   output logic [PAGE_W-1:0]             rsp_page_out,
   output logic [REF_OUT_W-1:0]          rsp_ref_count_out,
   output logic [CNT_W-1:0]              rsp_free_pages_out,
   output logic [CNT_W-1:0]              rsp_pages_in_use_out,
   output logic                          rsp_freed,
   // configuration port
   input  wire  logic                    csr_psel,
   input  wire  logic                    csr_penable,
   input  wire  logic                    csr_pwrite,
   input  wire  logic [CSR_ADDR_W-1:0]   csr_paddr,
   input  wire  logic [CSR_DATA_W-1:0]   csr_pwdata,
   output logic [CSR_DATA_W-1:0]         csr_prdata,
   output logic                          csr_pready
);

   localparam int AW = $clog2(MAX_PAGES);
   localparam int CW = (AW + 1 > CNT_W) ? AW + 1 : CNT_W;
   localparam logic [CW-1:0]       HEAD_EMPTY = CW'(32'h1_0000);
   localparam logic [CW-1:0]       MAX_C      = CW'(MAX_PAGES);
   localparam logic [REF_BITS-1:0] REF_MAX    = '1;
   localparam logic [AW-1:0]       SWEEP_LAST = '1;

   // Registers
   state_type            state_ff, state_in;
   logic [AW-1:0]        sweep_ff, sweep_in;
   logic                 sweep_rsp_ff, sweep_rsp_in;
   logic [CW-1:0]        head_ff, head_in;
   logic [CNT_W-1:0]     free_ff, free_in;
   logic [CNT_W-1:0]     use_ff, use_in;
   logic [CNT_W-1:0]     page_count_ff;
   logic [PAGE_W-1:0]    first_ff;
   mode_type             item_mode_ff;
   logic [PAGE_W-1:0]    item_pn_ff;
   logic [PID_W-1:0]     item_pid_ff;
   logic [VA_W-1:0]      item_va_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [PAGE_W-1:0]    rsp_page_ff, rsp_page_in;
   logic [REF_OUT_W-1:0] rsp_ref_ff, rsp_ref_in;
   logic                 rsp_freed_ff, rsp_freed_in;

   // RAM ports
   logic                 link_we, ref_we, own_we;
   logic [AW-1:0]        link_wa, ref_wa, own_wa;
   logic [PAGE_W-1:0]    link_wd, link_rd;
   logic [REF_BITS-1:0]  ref_wd, ref_rd;
   logic [OWNER_W-1:0]   own_wd, own_rd;
   logic [AW-1:0]        link_ra, ref_ra;

   logic                 req_take, rsp_take, exec_go, csr_write;
   mode_type             cur_mode;
   logic [PAGE_W-1:0]    cur_pn;
   logic [CW-1:0]        cnt_w, pc_ext, first_ext;
   logic                 pn_valid;
   logic [REF_BITS-1:0]  ref_new;

   // Handshakes
   assign req_take  = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign exec_go   = (state_ff == ST_EXEC) && (!rsp_valid_ff || !rsp_stall);

   // Configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         page_count_ff <= CNT_W'(MAX_PAGES_DEF);
         first_ff      <= '0;
      end else if (csr_write) begin
         unique case (reg_index_type'(csr_paddr[2]))
            REG_PAGE_COUNT: page_count_ff <= csr_pwdata[CNT_W-1:0];
            REG_FIRST_FREE: first_ff      <= csr_pwdata[PAGE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index_type'(csr_paddr[2]))
         REG_PAGE_COUNT: csr_prdata = CSR_DATA_W'(page_count_ff);
         REG_FIRST_FREE: csr_prdata = CSR_DATA_W'(first_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // Read addresses: straight from the ports at the accept edge, else from the item
   assign cur_mode = (state_ff == ST_IDLE) ? mode_type'(req_mode) : item_mode_ff;
   assign cur_pn   = (state_ff == ST_IDLE) ? req_page_number : item_pn_ff;
   assign link_ra  = AW'(head_ff);
   assign ref_ra   = (cur_mode == MODE_ALLOC) ? AW'(head_ff[PAGE_W-1:0]) : AW'(cur_pn);

   // Working page count and page check
   assign pc_ext    = CW'(page_count_ff);
   assign first_ext = CW'(first_ff);
   assign cnt_w     = (pc_ext > MAX_C) ? MAX_C : pc_ext;
   assign pn_valid  = CW'(item_pn_ff) < cnt_w;

   // Hold the item
   always_ff @(posedge clock) begin
      if (req_take) begin
         item_mode_ff <= mode_type'(req_mode);
         item_pn_ff   <= req_page_number;
         item_pid_ff  <= req_owner_pid_in;
         item_va_ff   <= req_owner_va_in;
      end
   end

   // Sequencer and read-modify-write datapath
   always_comb begin
      state_in      = state_ff;
      sweep_in      = sweep_ff;
      sweep_rsp_in  = sweep_rsp_ff;
      head_in       = head_ff;
      free_in       = free_ff;
      use_in        = use_ff;
      rsp_valid_in  = rsp_take ? 1'b0 : rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_page_in   = rsp_page_ff;
      rsp_ref_in    = rsp_ref_ff;
      rsp_freed_in  = rsp_freed_ff;
      link_we = 1'b0;
      link_wa = AW'(item_pn_ff);
      link_wd = head_ff[PAGE_W-1:0];
      ref_we  = 1'b0;
      ref_wa  = AW'(item_pn_ff);
      ref_wd  = '0;
      own_we  = 1'b0;
      own_wa  = AW'(item_pn_ff);
      own_wd  = {PID_NONE, {VA_W{1'b0}}};
      ref_new = ref_rd;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (mode_type'(req_mode) == MODE_INIT) begin
                  state_in     = ST_SWEEP;
                  sweep_in     = '0;
                  sweep_rsp_in = 1'b1;
               end else begin
                  state_in = ST_EXEC;
               end
            end
         end

         // Clear one entry of every table a cycle; links chain downwards
         ST_SWEEP: begin
            link_we = 1'b1;
            link_wa = sweep_ff;
            link_wd = PAGE_W'(sweep_ff - 1'b1);
            ref_we  = 1'b1;
            ref_wa  = sweep_ff;
            own_we  = 1'b1;
            own_wa  = sweep_ff;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == SWEEP_LAST) begin
               state_in = sweep_rsp_ff ? ST_EXEC : ST_IDLE;
               sweep_in = '0;
            end
         end

         ST_EXEC: begin
            if (exec_go) begin
               state_in      = ST_IDLE;
               sweep_rsp_in  = 1'b0;
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_OK;
               rsp_page_in   = item_pn_ff;
               rsp_freed_in  = 1'b0;
               rsp_ref_in    = pn_valid ? REF_OUT_W'(ref_rd) : '0;
               case (item_mode_ff) inside
                  MODE_INIT: begin
                     rsp_page_in = '0;
                     rsp_ref_in  = '0;
                     use_in      = '0;
                     if (first_ext < cnt_w) begin
                        head_in = cnt_w - 1'b1;
                        free_in = CNT_W'(cnt_w - first_ext);
                     end else begin
                        head_in = HEAD_EMPTY;
                        free_in = '0;
                     end
                  end

                  // Pop the head and give it count one
                  MODE_ALLOC: begin
                     if (free_ff == '0 || head_ff >= cnt_w) begin
                        rsp_status_in = STAT_EMPTY;
                        rsp_page_in   = '0;
                        rsp_ref_in    = '0;
                     end else begin
                        rsp_page_in = head_ff[PAGE_W-1:0];
                        free_in     = free_ff - 1'b1;
                        head_in     = (free_in == '0) ? HEAD_EMPTY : CW'(link_rd);
                        ref_we      = 1'b1;
                        ref_wa      = AW'(head_ff);
                        ref_wd      = REF_BITS'(1);
                        use_in      = (use_ff == CNT_SAT) ? use_ff : use_ff + 1'b1;
                        rsp_ref_in  = (head_ff[CW-1:PAGE_W] == '0) ? REF_OUT_W'(1)
                                                                  : REF_OUT_W'(ref_rd);
                     end
                  end

                  // Drop the count; at zero push the page and clear its owner
                  MODE_FREE: begin
                     if (!pn_valid || item_pn_ff < first_ff) begin
                        rsp_status_in = STAT_BAD_PAGE;
                        rsp_ref_in    = '0;
                     end else if (ref_rd == '0) begin
                        rsp_status_in = STAT_REF_ZERO;
                     end else begin
                        ref_new    = ref_rd - 1'b1;
                        ref_we     = 1'b1;
                        ref_wd     = ref_new;
                        rsp_ref_in = REF_OUT_W'(ref_new);
                        if (ref_new == '0) begin
                           use_in       = (use_ff == '0) ? use_ff : use_ff - 1'b1;
                           own_we       = 1'b1;
                           link_we      = 1'b1;
                           head_in      = CW'(item_pn_ff);
                           free_in      = (free_ff == CNT_SAT) ? free_ff : free_ff + 1'b1;
                           rsp_freed_in = 1'b1;
                        end
                     end
                  end

                  MODE_REF_INC: begin
                     if (!pn_valid) begin
                        rsp_status_in = STAT_BAD_PAGE;
                     end else begin
                        ref_new    = (ref_rd == REF_MAX) ? ref_rd : ref_rd + 1'b1;
                        ref_we     = 1'b1;
                        ref_wd     = ref_new;
                        rsp_ref_in = REF_OUT_W'(ref_new);
                     end
                  end

                  MODE_REF_DEC: begin
                     if (!pn_valid) begin
                        rsp_status_in = STAT_BAD_PAGE;
                     end else if (ref_rd == '0) begin
                        rsp_status_in = STAT_REF_ZERO;
                     end else begin
                        ref_new    = ref_rd - 1'b1;
                        ref_we     = 1'b1;
                        ref_wd     = ref_new;
                        rsp_ref_in = REF_OUT_W'(ref_new);
                     end
                  end

                  // Record or clear the owner; kernel pid is ignored
                  MODE_MAP, MODE_UNMAP: begin
                     if (item_pid_ff != PID_NONE) begin
                        if (!pn_valid) begin
                           rsp_status_in = STAT_BAD_PAGE;
                        end else begin
                           own_we = 1'b1;
                           if (item_mode_ff == MODE_MAP) begin
                              own_wd = {item_pid_ff, item_va_ff};
                           end
                        end
                     end
                  end

                  default: ;
               endcase
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         sweep_ff     <= '0;
         sweep_rsp_ff <= 1'b0;
         head_ff      <= HEAD_EMPTY;
         free_ff      <= '0;
         use_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         sweep_rsp_ff <= sweep_rsp_in;
         head_ff      <= head_in;
         free_ff      <= free_in;
         use_ff       <= use_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result word
   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_page_ff   <= rsp_page_in;
      rsp_ref_ff    <= rsp_ref_in;
      rsp_freed_ff  <= rsp_freed_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_page_out         = rsp_page_ff;
   assign rsp_ref_count_out    = rsp_ref_ff;
   assign rsp_free_pages_out   = free_ff;
   assign rsp_pages_in_use_out = use_ff;
   assign rsp_freed            = rsp_freed_ff;

   // Page tables
   pfa_ram #(.WIDTH(PAGE_W), .DEPTH(MAX_PAGES)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_wa),
      .wr_data (link_wd),
      .rd_addr (link_ra),
      .rd_data (link_rd)
   );

   pfa_ram #(.WIDTH(REF_BITS), .DEPTH(MAX_PAGES)) u_ref_ram (
      .clock   (clock),
      .wr_en   (ref_we),
      .wr_addr (ref_wa),
      .wr_data (ref_wd),
      .rd_addr (ref_ra),
      .rd_data (ref_rd)
   );

   pfa_ram #(.WIDTH(OWNER_W), .DEPTH(MAX_PAGES)) u_owner_ram (
      .clock   (clock),
      .wr_en   (own_we),
      .wr_addr (own_wa),
      .wr_data (own_wd),
      .rd_addr (ref_ra),
      .rd_data (own_rd)
   );

`ifndef SYNTH
   // Tables are only written while an item is being worked on or swept
   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      (link_we || ref_we || own_we) |-> (state_ff != ST_IDLE))
      else $error("table write while idle");

   // An accepted item leaves idle at once
   a_accept_moves: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == ST_EXEC || state_ff == ST_SWEEP))
      else $error("accepted item not started");

   // An empty list always carries the empty head marker
   a_empty_head: assert property (@(posedge clock) disable iff (reset)
      (free_ff == '0) |-> (head_ff == HEAD_EMPTY))
      else $error("empty list with a live head");

   // Every owner entry has been cleared by the time an item is worked on
   a_owner_known: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) |-> !$isunknown(own_rd))
      else $error("owner entry read before it was cleared");
`endif

endmodule

`default_nettype wire

// File: dv/pfa_checker.sv
module pfa_checker
   import pfa_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_stall,
   input  logic [2:0]              req_mode,
   input  logic [PAGE_W-1:0]       req_page_number,
   input  logic signed [PID_W-1:0] req_owner_pid_in,
   input  logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  logic [1:0]              rsp_status,
   input  logic [PAGE_W-1:0]       rsp_page_out,
   input  logic [REF_OUT_W-1:0]    rsp_ref_count_out,
   input  logic [CNT_W-1:0]        rsp_free_pages_out,
   input  logic [CNT_W-1:0]        rsp_pages_in_use_out,
   input  logic                    rsp_freed,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [CSR_DATA_W-1:0]   csr_pwdata,
   input  logic [CSR_DATA_W-1:0]   csr_prdata,
   input  logic                    csr_pready,
   output int                      fail_count,
   output int                      outstanding,
   output int                      words_checked,
   output int                      empty_allocs,
   output int                      bad_pages,
   output int                      zero_refs,
   output int                      pages_returned
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CNT_W-1:0] LIST_EMPTY = CNT_W'(MAX_PAGES_DEF);
   localparam int               REF_MAX    = (1 << REF_BITS_DEF) - 1;

   typedef struct packed {
      status_type             status;
      logic [PAGE_W-1:0]      page;
      logic [REF_OUT_W-1:0]   refs;
      logic [CNT_W-1:0]       free_cnt;
      logic [CNT_W-1:0]       in_use;
      logic                   freed;
   } frame_word_type;

   // Mirror of the allocator state. Owners are not kept: no result word shows them.
   logic [PAGE_W-1:0]       below_link [MAX_PAGES_DEF];
   logic [REF_BITS_DEF-1:0] ref_table  [MAX_PAGES_DEF];
   logic [CNT_W-1:0]        head;
   logic [CNT_W-1:0]        free_total;
   logic [CNT_W-1:0]        in_use_total;
   logic [CNT_W-1:0]        page_cfg;
   logic [PAGE_W-1:0]       first_cfg;

   frame_word_type awaited_words [$];
   int errs    = 0;
   int n_words = 0;
   int n_empty = 0;
   int n_bad   = 0;
   int n_zero  = 0;
   int n_ret   = 0;

   function automatic void wipe_tables();
      int i;
      for (i = 0; i < MAX_PAGES_DEF; i++) begin
         below_link[i] = '0;
         ref_table[i]  = '0;
      end
      head         = LIST_EMPTY;
      free_total   = '0;
      in_use_total = '0;
   endfunction

   // Push a page on top of the free list
   function automatic void return_page(input logic [PAGE_W-1:0] p);
      below_link[p] = head[PAGE_W-1:0];
      head          = {1'b0, p};
      if (free_total != CNT_SAT) free_total++;
   endfunction

   // Apply one item to the mirror and work out the word it should produce
   function automatic frame_word_type apply_item(input logic [2:0]        mode,
                                                  input logic [PAGE_W-1:0] pn,
                                                  input logic [PID_W-1:0]  pid);
      frame_word_type   w;
      logic [CNT_W-1:0] limit;
      logic             in_range;
      logic             show;
      int               p;
      limit    = (page_cfg > CNT_W'(MAX_PAGES_DEF)) ? CNT_W'(MAX_PAGES_DEF) : page_cfg;
      in_range = {1'b0, pn} < limit;
      w.status = STAT_OK;
      w.page   = pn;
      w.freed  = 1'b0;
      show     = in_range;
      case (mode) inside
         MODE_INIT: begin
            wipe_tables();
            for (p = int'(first_cfg); p < int'(limit); p++) return_page(PAGE_W'(p));
            w.page = '0;
            show   = 1'b0;
         end
         MODE_ALLOC: begin
            if (free_total == 0 || head >= limit) begin
               w.status = STAT_EMPTY;
               w.page   = '0;
               show     = 1'b0;
            end else begin
               w.page = head[PAGE_W-1:0];
               free_total--;
               head = (free_total == 0) ? LIST_EMPTY : {1'b0, below_link[w.page]};
               ref_table[w.page] = 1;
               if (in_use_total != CNT_SAT) in_use_total++;
               show = 1'b1;
            end
         end
         MODE_FREE: begin
            if (!in_range || pn < first_cfg) begin
               w.status = STAT_BAD_PAGE;
               show     = 1'b0;
            end else if (ref_table[pn] == 0) begin
               w.status = STAT_REF_ZERO;
            end else begin
               ref_table[pn]--;
               // last reference gone: back onto the list
               if (ref_table[pn] == 0) begin
                  if (in_use_total != 0) in_use_total--;
                  return_page(pn);
                  w.freed = 1'b1;
               end
            end
         end
         MODE_REF_INC: begin
            if (!in_range) w.status = STAT_BAD_PAGE;
            else if (ref_table[pn] != REF_MAX) ref_table[pn]++;
         end
         MODE_REF_DEC: begin
            if (!in_range) w.status = STAT_BAD_PAGE;
            else if (ref_table[pn] == 0) w.status = STAT_REF_ZERO;
            else ref_table[pn]--;
         end
         MODE_MAP, MODE_UNMAP: begin
            // kernel pid skips the range check altogether
            if (pid != PID_NONE && !in_range) w.status = STAT_BAD_PAGE;
         end
         default: begin
         end
      endcase
      w.refs     = show ? REF_OUT_W'(ref_table[w.page]) : '0;
      w.free_cnt = free_total;
      w.in_use   = in_use_total;
      return w;
   endfunction

   task automatic check_field(input string name, input logic [VA_W-1:0] want,
                              input logic [VA_W-1:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         errs++;
      end
   endtask

   always @(posedge clock) begin
      frame_word_type want;
      if (reset) begin
         wipe_tables();
         page_cfg  = CNT_W'(MAX_PAGES_DEF);
         first_cfg = '0;
         awaited_words.delete();
      end else begin
         // track register writes, check read-back
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               case (reg_index_type'(csr_paddr[2]))
                  REG_PAGE_COUNT: page_cfg  = csr_pwdata[CNT_W-1:0];
                  REG_FIRST_FREE: first_cfg = csr_pwdata[PAGE_W-1:0];
                  default: ;
               endcase
            end else begin
               check_field("csr_prdata",
                           (reg_index_type'(csr_paddr[2]) == REG_FIRST_FREE) ?
                           VA_W'(first_cfg) : VA_W'(page_cfg), VA_W'(csr_prdata));
            end
         end
         // compare each delivered word with the oldest expectation
         if (rsp_valid && !rsp_stall) begin
            if (awaited_words.size() == 0) begin
               $error("result word with no expectation waiting (page %0d)", rsp_page_out);
               errs++;
            end else begin
               want = awaited_words.pop_front();
               check_field("status", VA_W'(want.status), VA_W'(rsp_status));
               check_field("page_out", VA_W'(want.page), VA_W'(rsp_page_out));
               check_field("ref_count_out", VA_W'(want.refs), VA_W'(rsp_ref_count_out));
               check_field("free_pages_out", VA_W'(want.free_cnt),
                           VA_W'(rsp_free_pages_out));
               check_field("pages_in_use_out", VA_W'(want.in_use),
                           VA_W'(rsp_pages_in_use_out));
               check_field("freed", VA_W'(want.freed), VA_W'(rsp_freed));
               n_words++;
               if (want.status == STAT_EMPTY) n_empty++;
               if (want.status == STAT_BAD_PAGE) n_bad++;
               if (want.status == STAT_REF_ZERO) n_zero++;
               if (want.freed) n_ret++;
            end
         end
         if (req_valid && !req_stall)
            awaited_words.push_back(apply_item(req_mode, req_page_number, req_owner_pid_in));
      end
      fail_count     <= errs;
      outstanding    <= awaited_words.size();
      words_checked  <= n_words;
      empty_allocs   <= n_empty;
      bad_pages      <= n_bad;
      zero_refs      <= n_zero;
      pages_returned <= n_ret;
   end

endmodule

// File: dv/testbench.sv
module testbench
   import pfa_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] MODE_UNUSED   = 3'd7;
   localparam int         IDLE_PCT      = 14;
   localparam int         HOLD_CYCLES   = 400;
   localparam int         SETTLE_CYCLES = 4;
   localparam int         DRAIN_CYCLES  = 20;
   localparam int         CYCLE_LIMIT   = 2_500_000;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [2:0]              req_mode = '0;
   logic [PAGE_W-1:0]       req_page_number = '0;
   logic signed [PID_W-1:0] req_owner_pid_in = '0;
   logic [VA_W-1:0]         req_owner_va_in = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [1:0]              rsp_status;
   logic [PAGE_W-1:0]       rsp_page_out;
   logic [REF_OUT_W-1:0]    rsp_ref_count_out;
   logic [CNT_W-1:0]        rsp_free_pages_out;
   logic [CNT_W-1:0]        rsp_pages_in_use_out;
   logic                    rsp_freed;
   logic                    csr_psel = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_paddr = '0;
   logic [CSR_DATA_W-1:0]   csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]   csr_prdata;
   logic                    csr_pready;

   int fail_count;
   int outstanding;
   int words_checked;
   int empty_allocs;
   int bad_pages;
   int zero_refs;
   int pages_returned;

   bit calm         = 1'b0;
   bit hold_off_req = 1'b0;
   int cur_count    = MAX_PAGES_DEF;
   int cur_first    = 0;
   int settings_used = 0;
   int inits_sent   = 0;
   int cycle_count  = 0;

   page_frame_allocator_refcount_top u_dut (.*);
   pfa_checker u_checker (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // hard stop on a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // receiver: random stalls, or one long hold-off when asked
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
         end
      end
   end

   task automatic drain_results();
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic csr_access(input logic wr, input reg_index_type idx,
                             input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Drop valid, let the block go idle, then rewrite both registers and read them back
   task automatic set_config(input logic [CNT_W-1:0] pages, input logic [PAGE_W-1:0] first);
      req_valid <= 1'b0;
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_access(1'b1, REG_PAGE_COUNT, CSR_DATA_W'(pages));
      csr_access(1'b1, REG_FIRST_FREE, CSR_DATA_W'(first));
      csr_access(1'b0, REG_PAGE_COUNT, '0);
      csr_access(1'b0, REG_FIRST_FREE, '0);
      cur_count = int'(pages);
      cur_first = int'(first);
      settings_used++;
   endtask

   // Offer one word and hold it until the block takes it
   task automatic send_item(input logic [2:0] mode, input logic [PAGE_W-1:0] pn,
                            input logic [PID_W-1:0] pid, input logic [VA_W-1:0] va);
      if (!calm) begin
         while ($urandom_range(0, 99) < IDLE_PCT) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid        <= 1'b1;
      req_mode         <= mode;
      req_page_number  <= pn;
      req_owner_pid_in <= pid;
      req_owner_va_in  <= va;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (mode == MODE_INIT) inits_sent++;
   endtask

   // Mostly pages near the top of the working range, where the list lives
   function automatic logic [PAGE_W-1:0] pick_page();
      int hi;
      int lo;
      int r;
      hi = cur_count - 1;
      lo = (hi > 47) ? hi - 47 : 0;
      if (cur_first > lo && cur_first <= hi) lo = cur_first;
      r = $urandom_range(0, 99);
      if (r < 70) return PAGE_W'($urandom_range(lo, hi));
      if (r < 90) return PAGE_W'($urandom_range(0, (hi + 8 > 65535) ? 65535 : hi + 8));
      return PAGE_W'($urandom());
   endfunction

   task automatic random_phase(input logic [CNT_W-1:0] pages, input logic [PAGE_W-1:0] first,
                               input bit fresh, input int n, input int hold_at,
                               input int pause_at, input int burst_at, input bit quiet);
      int                k;
      int                b;
      int                roll;
      logic [2:0]        mode;
      logic [PAGE_W-1:0] pn;
      logic [PID_W-1:0]  pid;
      logic [VA_W-1:0]   va;
      set_config(pages, first);
      calm = quiet;
      if (fresh) send_item(MODE_INIT, PAGE_W'($urandom()), PID_W'($urandom()), '0);
      for (k = 0; k < n; k++) begin
         if (k == hold_at) hold_off_req = 1'b1;
         if (k == pause_at) begin
            req_valid <= 1'b0;
            drain_results();
         end
         // hammer one page until its count saturates
         if (k == burst_at) begin
            pn = pick_page();
            for (b = 0; b < 260; b++)
               send_item(MODE_REF_INC, pn, PID_W'($urandom()), VA_W'($urandom()));
         end
         roll = $urandom_range(0, 99);
         pn   = pick_page();
         pid  = ($urandom_range(0, 3) == 0) ? PID_NONE : PID_W'($urandom());
         va   = VA_W'({$urandom(), $urandom()});
         if (roll < 30)      mode = MODE_ALLOC;
         else if (roll < 55) mode = MODE_FREE;
         else if (roll < 67) mode = MODE_REF_INC;
         else if (roll < 77) mode = MODE_REF_DEC;
         else if (roll < 86) mode = MODE_MAP;
         else if (roll < 95) mode = MODE_UNMAP;
         else                mode = MODE_UNUSED;
         send_item(mode, pn, pid, va);
      end
      calm = 1'b0;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // small table: alloc, refs, double free, range errors, owners
      set_config(17'd16, 16'd4);
      send_item(MODE_INIT, 16'hFFFF, 16'h7FFF, '1);
      send_item(MODE_ALLOC, 0, 0, 0);
      send_item(MODE_ALLOC, 0, 0, 0);
      send_item(MODE_REF_INC, 15, 0, 0);
      send_item(MODE_FREE, 15, 0, 0);
      send_item(MODE_FREE, 15, 0, 0);
      send_item(MODE_FREE, 15, 0, 0);
      send_item(MODE_REF_DEC, 15, 0, 0);
      send_item(MODE_FREE, 2, 0, 0);
      send_item(MODE_FREE, 16, 0, 0);
      send_item(MODE_FREE, 16'hFFFF, 0, 0);
      send_item(MODE_REF_INC, 16'hFFFF, 0, 0);
      send_item(MODE_MAP, 16'hFFFF, PID_NONE, '1);
      send_item(MODE_MAP, 5, 16'h7FFF, '1);
      send_item(MODE_UNMAP, 5, 16'h8000, 0);
      send_item(MODE_MAP, 16, 0, 48'h1000);
      // bump a listed page, then free it: it lands on the list twice
      send_item(MODE_REF_INC, 4, 0, 0);
      send_item(MODE_FREE, 4, 0, 0);
      send_item(MODE_REF_INC, 5, 0, 0);
      send_item(MODE_FREE, 5, 0, 0);
      send_item(MODE_UNUSED, 14, 0, 0);
      send_item(MODE_REF_DEC, 14, 0, 0);

      // a single page at the very top; run the list dry
      set_config(17'd65536, 16'd65535);
      send_item(MODE_INIT, 0, 0, 0);
      send_item(MODE_ALLOC, 0, 0, 0);
      send_item(MODE_ALLOC, 0, 0, 0);
      send_item(MODE_FREE, 16'd65534, 0, 0);
      send_item(MODE_FREE, 16'd65535, 0, 0);
      send_item(MODE_ALLOC, 0, 0, 0);

      // first free page beyond the count leaves the list empty
      set_config(17'd1, 16'd65535);
      send_item(MODE_INIT, 0, 0, 0);
      send_item(MODE_ALLOC, 0, 0, 0);

      // random traffic over several settings
      random_phase(17'd64, 16'd8, 1'b1, 150, -1, -1, 70, 1'b0);
      random_phase(17'd40, 16'd8, 1'b0, 150, -1, -1, -1, 1'b0);
      random_phase(17'd65536, 16'd0, 1'b1, 200, -1, 120, -1, 1'b1);
      random_phase(17'd20, 16'd0, 1'b1, 200, 60, -1, -1, 1'b0);
      random_phase(17'd65536, 16'd65520, 1'b1, 200, -1, -1, -1, 1'b0);

      // wind down and report
      req_valid <= 1'b0;
      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Checked %0d result words over %0d register settings and %0d list rebuilds.",
               words_checked, settings_used, inits_sent);
      $display("Saw %0d empty allocs, %0d bad pages, %0d zero counts, %0d pages returned.",
               empty_allocs, bad_pages, zero_refs, pages_returned);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
